/* rtl/hsha_pkg.sv */
// shared types, constants and helper functions for the sha-1 / hmac byte engine
`timescale 1ns / 1ps
package hsha_pkg;

    localparam logic [4:0] KEY_BYTES = 5'd16;

    localparam logic [1:0] CFG_HMAC_ENABLE = 2'd0;
    localparam logic [1:0] CFG_KEY_UPPER   = 2'd1;
    localparam logic [1:0] CFG_KEY_LOWER   = 2'd2;
    localparam logic [1:0] CFG_KEY_SIZE    = 2'd3;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5C;
    localparam logic [7:0] MARK_BYTE = 8'h80;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_item;

    // request from the sequencer to the compression core
    typedef struct packed {
        logic       init;
        logic       wr;
        logic       count;
        logic [7:0] data;
    } t_core_req;

    typedef struct packed {
        logic        busy;
        logic [5:0]  fill;
        logic [63:0] bits;
    } t_core_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSG,
        ST_KPAD,
        ST_ITEM,
        ST_PAD80,
        ST_ZERO,
        ST_LEN,
        ST_DONE,
        ST_INNER,
        ST_OUT
    } t_state;

    function automatic logic [31:0] round_const(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)      k = 32'h5A827999;
        else if (r < 7'd40) k = 32'h6ED9EBA1;
        else if (r < 7'd60) k = 32'h8F1BBCDC;
        else                k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_fn(input logic [6:0] r, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)      f = (b & c) | (~b & d);
        else if (r < 7'd40) f = b ^ c ^ d;
        else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction

    // key byte xor pad; bytes past the clipped key length are the bare pad
    function automatic logic [7:0] key_pad_byte(input logic [63:0] upper,
                                                input logic [63:0] lower,
                                                input logic [4:0] klen,
                                                input logic [5:0] idx,
                                                input logic [7:0] pad);
        logic [4:0]  len;
        logic [63:0] src;
        logic [63:0] sh;
        logic [7:0]  k;
        len = (klen > KEY_BYTES) ? KEY_BYTES : klen;
        src = idx[3] ? lower : upper;
        sh  = src >> (6'd56 - {idx[2:0], 3'b000});
        k   = ({1'b0, idx} < {1'b0, len}) ? sh[7:0] : 8'h00;
        return k ^ pad;
    endfunction

endpackage

/* rtl/hsha_core.sv */
// sha-1 block buffer, message schedule and one-round-per-cycle compression unit
`timescale 1ns / 1ps
module hsha_core
    import hsha_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_core_req      i_req,
    output t_core_sts      o_sts,
    output logic [159:0]   o_chain
);

    logic [511:0] r_blk;
    logic [31:0]  r_h [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [6:0]   r_round;
    logic         r_busy;
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;

    logic [31:0] x_sched;
    logic [31:0] w_cur;
    logic [31:0] t_sum;

    assign x_sched = r_blk[511-32*13 -: 32] ^ r_blk[511-32*8 -: 32]
                   ^ r_blk[511-32*2 -: 32] ^ r_blk[511:480];
    assign w_cur   = (r_round < 7'd16) ? r_blk[511:480] : {x_sched[30:0], x_sched[31]};
    assign t_sum   = {r_a[26:0], r_a[31:27]} + round_fn(r_round, r_b, r_c, r_d)
                   + r_e + w_cur + round_const(r_round);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_fill  <= '0;
            r_bits  <= '0;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0;
            for (int i = 0; i < 5; i++) r_h[i] <= SHA1_IV[159-32*i -: 32];
        end else if (r_busy) begin
            if (r_round == 7'd80) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
                r_busy <= 1'b0;
            end else begin
                r_blk   <= {r_blk[479:0], w_cur};
                r_e     <= r_d;
                r_d     <= r_c;
                r_c     <= {r_b[1:0], r_b[31:2]};
                r_b     <= r_a;
                r_a     <= t_sum;
                r_round <= r_round + 7'd1;
            end
        end else begin
            if (i_req.init) begin
                r_fill <= '0;
                r_bits <= '0;
                for (int i = 0; i < 5; i++) r_h[i] <= SHA1_IV[159-32*i -: 32];
            end else if (i_req.wr) begin
                r_blk  <= {r_blk[503:0], i_req.data};
                r_fill <= r_fill + 6'd1;
                if (i_req.count) r_bits <= r_bits + 64'd8;
                // block full: start the 80 rounds
                if (r_fill == 6'd63) begin
                    r_busy  <= 1'b1;
                    r_round <= '0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.fill = r_fill;
    assign o_sts.bits = r_bits;
    assign o_chain    = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};

endmodule

/* rtl/hmac_sha1_byte_stream.sv */
// top level: request sequencer, padding and hmac key schedule around the sha-1 core
`timescale 1ns / 1ps
// Byte-stream SHA-1 / HMAC-SHA1 engine. One request carries one message byte
// (byte_present) and/or the end mark; on the end mark the block returns five
// 32-bit big-endian digest words, word 4 flagged last_word. With hmac_enable
// set when a message starts, the key XOR 0x36 block is absorbed first and the
// outer hash over key XOR 0x5C plus the inner digest follows the end mark.
// Keys are up to 16 bytes, key byte 0 in the top bits of key_upper; a key
// size above 16 counts as 16. A message byte is first accepted into the held
// request, then written into the block buffer; every filled 64-byte block
// then runs its 80 rounds and the chain add in the single shared round unit.
// Padding adds up to 72 pad bytes plus one or two compressions; HMAC adds 64
// key-pad bytes and one compression at message start, and at the end 84
// bytes, a second padding pass of 44 bytes and two more compressions. Input
// stall is low only while idle, or between message bytes while the round unit
// is free; it stays high while a held request is written, pad bytes are
// produced and the digest is read out. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module hmac_sha1_byte_stream
    import hsha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_state       r_state, n_state;
    t_core_req    core_req;
    t_core_sts    core_sts;
    logic [159:0] chain;

    // configuration registers
    logic         r_hmac_enable;
    logic [63:0]  r_key_upper;
    logic [63:0]  r_key_lower;
    logic [4:0]   r_key_size;

    logic         r_hmac;      // mode latched at message start
    logic         r_outer;     // working on the outer hash
    t_in_item     r_item;      // held request
    logic [5:0]   r_cnt;
    logic [159:0] r_inner;     // inner digest, shifted out a byte at a time

    logic         in_acc;
    logic         in_live;
    logic [63:0]  len_sh;
    logic [159:0] chain_sh;

    assign o_cfg_ready = 1'b1;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign in_live = i_in_data.byte_present || i_in_data.end_of_message;
    assign len_sh  = core_sts.bits >> (6'd56 - {r_cnt[2:0], 3'b000});
    assign chain_sh = chain << {r_cnt[2:0], 5'b00000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hmac_enable <= 1'b1;
            r_key_upper   <= '0;
            r_key_lower   <= '0;
            r_key_size    <= KEY_BYTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HMAC_ENABLE: r_hmac_enable <= i_cfg_data[0];
                CFG_KEY_UPPER:   r_key_upper   <= i_cfg_data;
                CFG_KEY_LOWER:   r_key_lower   <= i_cfg_data;
                CFG_KEY_SIZE:    r_key_size    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && in_live) n_state = r_hmac_enable ? ST_KPAD : ST_ITEM;
            end
            ST_MSG: begin
                if (in_acc && in_live) n_state = ST_ITEM;
            end
            ST_KPAD: begin
                if (!core_sts.busy && r_cnt == 6'd63) n_state = r_outer ? ST_INNER : ST_ITEM;
            end
            ST_ITEM: begin
                if (!core_sts.busy) n_state = r_item.end_of_message ? ST_PAD80 : ST_MSG;
            end
            ST_PAD80: begin
                if (!core_sts.busy) n_state = ST_ZERO;
            end
            ST_ZERO: begin
                if (!core_sts.busy && core_sts.fill == 6'd56) n_state = ST_LEN;
            end
            ST_LEN: begin
                if (!core_sts.busy && r_cnt[2:0] == 3'd7) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!core_sts.busy) n_state = (r_hmac && !r_outer) ? ST_KPAD : ST_OUT;
            end
            ST_INNER: begin
                if (!core_sts.busy && r_cnt == 6'd19) n_state = ST_PAD80;
            end
            ST_OUT: begin
                if (!i_out_stall && r_cnt[2:0] == 3'd4) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and core requests
    always_comb begin
        core_req    = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                core_req.init = in_acc && in_live;
            end
            ST_MSG: o_in_stall = core_sts.busy;
            ST_KPAD: begin
                core_req.wr    = !core_sts.busy;
                core_req.count = 1'b1;
                core_req.data  = key_pad_byte(r_key_upper, r_key_lower, r_key_size,
                                              r_cnt, r_outer ? OPAD_BYTE : IPAD_BYTE);
            end
            ST_ITEM: begin
                core_req.wr    = !core_sts.busy && r_item.byte_present;
                core_req.count = 1'b1;
                core_req.data  = r_item.data_byte;
            end
            ST_PAD80: begin
                core_req.wr   = !core_sts.busy;
                core_req.data = MARK_BYTE;
            end
            ST_ZERO: core_req.wr = !core_sts.busy && core_sts.fill != 6'd56;
            ST_LEN: begin
                core_req.wr   = !core_sts.busy;
                core_req.data = len_sh[7:0];
            end
            ST_DONE: core_req.init = !core_sts.busy && r_hmac && !r_outer;
            ST_INNER: begin
                core_req.wr    = !core_sts.busy;
                core_req.count = 1'b1;
                core_req.data  = r_inner[159:152];
            end
            ST_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_out_data.digest_word = chain_sh[159:128];
    assign o_out_data.word_number = r_cnt[2:0];
    assign o_out_data.last_word   = (r_cnt[2:0] == 3'd4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hmac  <= 1'b0;
            r_outer <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_hmac  <= r_hmac_enable;
                    r_outer <= 1'b0;
                    r_cnt   <= '0;
                end
                ST_KPAD, ST_INNER: if (!core_sts.busy) r_cnt <= (n_state == r_state) ?
                                                                r_cnt + 6'd1 : '0;
                ST_ZERO: r_cnt <= '0;
                ST_LEN: if (!core_sts.busy) r_cnt <= r_cnt + 6'd1;
                ST_DONE: begin
                    r_cnt <= '0;
                    if (!core_sts.busy && r_hmac && !r_outer) r_outer <= 1'b1;
                end
                ST_OUT: if (!i_out_stall) r_cnt <= r_cnt + 6'd1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) r_item <= i_in_data;
        if (r_state == ST_DONE && !core_sts.busy) r_inner <= chain;
        else if (r_state == ST_INNER && !core_sts.busy) r_inner <= {r_inner[151:0], 8'h00};
    end

    hsha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .o_sts   (core_sts),
        .o_chain (chain)
    );

`ifndef SYNTHESIS
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_req.wr |-> !core_sts.busy) else $error("byte written during rounds");
    a_no_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !core_sts.busy) else $error("digest shown during rounds");
    a_accept_idle_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !core_sts.busy) else $error("request taken during rounds");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_word) |=> !o_out_valid)
        else $error("extra digest word");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("request taken during digest output");
`endif

endmodule

/* bench/tb.sv */
// self-checking bench for the sha-1 / hmac-sha1 byte stream engine
`timescale 1ns / 1ps
module tb;
    import hsha_pkg::*;

    // expected digest words, worked out from the requests as they are accepted
    class digest_scoreboard;
        logic        hmac_on;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [4:0]  key_len;
        logic [31:0] chain [5];
        logic [7:0]  blk [64];
        logic [5:0]  fill;
        logic [63:0] bit_count;
        int          phase;       // 0 idle, 1 plain message, 2 hmac inner message
        t_out_item   digest_q [$];
        int          mismatches;

        function new();
            hmac_on    = 1'b1;
            key_hi     = '0;
            key_lo     = '0;
            key_len    = 5'd16;
            phase      = 0;
            mismatches = 0;
            start_hash();
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                CFG_HMAC_ENABLE: hmac_on = val[0];
                CFG_KEY_UPPER:   key_hi  = val;
                CFG_KEY_LOWER:   key_lo  = val;
                CFG_KEY_SIZE:    key_len = val[4:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void start_hash();
            chain[0] = 32'h67452301; chain[1] = 32'hEFCDAB89; chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476; chain[4] = 32'hC3D2E1F0;
            fill      = '0;
            bit_count = '0;
        endfunction

        function void compress();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, k, t;
            for (int r = 0; r < 80; r++) begin
                if (r < 16) w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
                else w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r < 20) begin
                    f = (b & c) | (~b & d); k = 32'h5A827999;
                end else if (r < 40) begin
                    f = b ^ c ^ d; k = 32'h6ED9EBA1;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d; k = 32'hCA62C1D6;
                end
                t = rotl(a, 5) + f + e + w[r] + k;
                e = d; d = c; c = rotl(b, 30); b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
            fill = '0;
        endfunction

        function void absorb(logic [7:0] b);
            blk[fill] = b;
            fill      = fill + 6'd1;
            bit_count = bit_count + 64'd8;
            if (fill == 6'd0) compress();
        endfunction

        function void finish();
            int pos;
            pos = fill;
            blk[pos] = MARK_BYTE;
            pos++;
            if (pos > 56) begin
                while (pos < 64) blk[pos++] = 8'h00;
                compress();
                pos = 0;
            end
            while (pos < 56) blk[pos++] = 8'h00;
            for (int i = 0; i < 8; i++) blk[56 + i] = bit_count[63 - 8*i -: 8];
            compress();
        endfunction

        function void absorb_key_pad(logic [7:0] pad);
            int          len;
            logic [63:0] src;
            logic [7:0]  kb;
            len = (key_len > 5'd16) ? 16 : key_len;
            for (int i = 0; i < 64; i++) begin
                kb = 8'h00;
                if (i < len) begin
                    src = (i < 8) ? key_hi : key_lo;
                    kb  = src[63 - 8*(i % 8) -: 8];
                end
                absorb(kb ^ pad);
            end
        endfunction

        function void note_request(t_in_item req);
            logic [31:0] inner [5];
            t_out_item   word;
            if (!req.byte_present && !req.end_of_message) return;
            // mode is latched by the first request of a message
            if (phase == 0) begin
                start_hash();
                if (hmac_on) begin
                    phase = 2;
                    absorb_key_pad(IPAD_BYTE);
                end else begin
                    phase = 1;
                end
            end
            if (req.byte_present) absorb(req.data_byte);
            if (!req.end_of_message) return;
            finish();
            if (phase == 2) begin
                inner = chain;
                start_hash();
                absorb_key_pad(OPAD_BYTE);
                for (int i = 0; i < 20; i++) absorb(inner[i/4][31 - 8*(i % 4) -: 8]);
                finish();
            end
            phase = 0;
            for (int i = 0; i < 5; i++) begin
                word.digest_word = chain[i];
                word.word_number = i[2:0];
                word.last_word   = (i == 4);
                digest_q.push_back(word);
            end
        endfunction

        function void check_word(t_out_item got);
            t_out_item want;
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h num %0d last %b",
                             got.digest_word, got.word_number, got.last_word);
                return;
            end
            want = digest_q.pop_front();
            if (got.digest_word !== want.digest_word || got.word_number !== want.word_number
                    || got.last_word !== want.last_word) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("digest mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                             want.digest_word, want.word_number, want.last_word,
                             got.digest_word, got.word_number, got.last_word);
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_HMAC_ENABLE;
    logic [63:0] i_cfg_data = '0;

    digest_scoreboard sb = new();
    int  stall_pct = 30;   // receiver stall odds per cycle, changed by phase
    int  stall_hold = 0;
    bit  gaps_on = 1'b1;   // sender gaps on or off, changed by phase
    int  sent = 0;

    hmac_sha1_byte_stream i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // output side: check accepted words, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_word(o_out_data);
        if (stall_hold > 0) begin
            stall_hold--;
        end else if ($urandom_range(0, 99) < 3) begin
            // occasional long back-pressure stretch
            i_out_stall <= 1'b1;
            stall_hold  = $urandom_range(10, 50);
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_request(logic [7:0] b, logic present, logic eom);
        t_in_item req;
        int       gap;
        req.data_byte      = b;
        req.byte_present   = present;
        req.end_of_message = eom;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
        sent++;
        gap = 0;
        if (gaps_on) begin
            gap = $urandom_range(0, 99);
            gap = (gap < 60) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // message of n bytes, the end mark on the last byte or alone when n is 0
    task automatic send_message(int n);
        for (int i = 0; i < n; i++) begin
            // stray idle requests must leave the hash untouched
            if ($urandom_range(0, 19) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1, i == n - 1);
        end
        if (n == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // let every digest drain before touching the registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 12);
        if (r < 93) return $urandom_range(50, 70);   // around the padding boundaries
        return $urandom_range(110, 135);
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings (hmac, all-zero 16-byte key)
        send_request(8'h00, 1'b0, 1'b1);          // empty message
        send_request(8'hFF, 1'b0, 1'b0);          // idle request
        send_request(8'hFF, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b0, 1'b1);          // end mark alone after a byte
        wait_idle();
        write_reg(CFG_HMAC_ENABLE, 64'd0);
        send_request(8'h00, 1'b0, 1'b1);          // plain sha-1 of empty message
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        wait_idle();
        write_reg(CFG_HMAC_ENABLE, 64'd1);
        write_reg(CFG_KEY_UPPER, '1);
        write_reg(CFG_KEY_LOWER, '1);
        write_reg(CFG_KEY_SIZE, 64'd31);          // long key size clips to 16
        send_request(8'h5A, 1'b1, 1'b1);
        send_request(8'hA5, 1'b0, 1'b1);
        wait_idle();
        write_reg(CFG_KEY_SIZE, 64'd0);           // bare pads
        send_request(8'h80, 1'b1, 1'b1);
        wait_idle();

        // random phases, each with fresh settings and handshake behavior
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_HMAC_ENABLE, 64'(p % 3 != 1));
            write_reg(CFG_KEY_UPPER, {$urandom, $urandom});
            write_reg(CFG_KEY_LOWER, (p == 2) ? 64'd0 : {$urandom, $urandom});
            write_reg(CFG_KEY_SIZE, (p == 0) ? 64'd16 : (p == 3) ? 64'd1 :
                                    64'($urandom_range(0, 31)));
            stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 75;
            gaps_on   = (p != 4);
            while (sent < 25 + 48 * (p + 1)) send_message(pick_length());
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end
endmodule

/* hmac_sha1_byte_stream.f */
rtl/hsha_pkg.sv
rtl/hsha_core.sv
rtl/hmac_sha1_byte_stream.sv
bench/tb.sv
